FILE: hw/rtl/msblit_pkg.sv
// shared types and constants of the masked sprite blitter
package msblit_pkg;

	localparam int FB_STRIDE_DEF = 32;
	localparam int FB_ROWS_DEF = 256;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		CMD_START  = 2'd0,
		CMD_SOURCE = 2'd1,
		CMD_READ   = 2'd2,
		CMD_WRITE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		OP_MERGE = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2
	} op_kind_t;

	typedef enum logic [1:0] {
		BK_ISSUE = 2'd0,
		BK_MERGE = 2'd1,
		BK_READ  = 2'd2
	} bk_state_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [7:0]  pos_x;
		logic [7:0]  pos_y;
		logic [5:0]  width_bytes;
		logic [8:0]  height_rows;
		logic [7:0]  image_byte;
		logic [7:0]  mask_byte;
		logic [12:0] address;
		logic [7:0]  write_data;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_data;
	} out_item_t;

	// one framebuffer operation as queued between front and back
	typedef struct packed {
		op_kind_t   kind;
		logic       hit;
		logic [7:0] keep;
		logic [7:0] data;
	} op_t;

endpackage

FILE: hw/rtl/msblit_if.sv
// valid/ready channels for command items and read results
interface msblit_in_if;
	logic                 valid;
	logic                 ready;
	msblit_pkg::in_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface msblit_out_if;
	logic                  valid;
	logic                  ready;
	msblit_pkg::out_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

FILE: hw/rtl/masked_sprite_blit.sv
// masked 1bpp sprite blitter with its own framebuffer
// source byte: memory read then merge write, and a second read and merge write when a shifted row's last byte
// also merges the trailing column; a plain write is a single memory write, a read a memory read then a result load
// a read result passes the queue, the back's read state and the result register, and waits while that register is full
// front takes an item per cycle while the queue has room, except just after a trailing column
// reset clears control state only; framebuffer contents are undefined until written
module masked_sprite_blit #(
	parameter int FB_STRIDE = msblit_pkg::FB_STRIDE_DEF,
	parameter int FB_ROWS = msblit_pkg::FB_ROWS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	msblit_in_if.sink     req,
	msblit_out_if.source  rsp
);
	localparam int FB_SIZE = FB_STRIDE * FB_ROWS;
	localparam int AW = (FB_SIZE > 1) ? $clog2(FB_SIZE) : 1;
	localparam int QW = $bits(msblit_pkg::op_t) + AW;

	logic                push;
	msblit_pkg::op_t     push_op;
	logic [AW-1:0]       push_addr;
	logic                full;
	logic                pop;
	logic                empty;
	logic [QW-1:0]       head;
	msblit_pkg::op_t     head_op;
	logic [AW-1:0]       head_addr;

	assign head_op = head[QW-1:AW];
	assign head_addr = head[AW-1:0];

	msblit_front #(
		.FB_STRIDE(FB_STRIDE),
		.FB_ROWS(FB_ROWS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.push(push),
		.push_op(push_op),
		.push_addr(push_addr),
		.full(full)
	);

	msblit_fifo #(
		.W(QW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data({push_op, push_addr}),
		.full(full),
		.pop(pop),
		.pop_data(head),
		.empty(empty)
	);

	msblit_back #(
		.FB_STRIDE(FB_STRIDE),
		.FB_ROWS(FB_ROWS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.empty(empty),
		.head_op(head_op),
		.head_addr(head_addr),
		.pop(pop),
		.rsp(rsp)
	);
endmodule

FILE: hw/rtl/msblit_fifo.sv
// short operation queue between front and back
module msblit_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         empty
);
	logic [W-1:0] entry_q [msblit_pkg::QUEUE_DEPTH];
	logic [msblit_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [msblit_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [msblit_pkg::QUEUE_PTR_W:0]   count_q;

	assign full = (count_q == (msblit_pkg::QUEUE_PTR_W + 1)'(msblit_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push && !full, pop && !empty})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

FILE: hw/rtl/msblit_front.sv
// front: takes command items, tracks the blit and turns bytes into framebuffer operations
module msblit_front #(
	parameter int FB_STRIDE = msblit_pkg::FB_STRIDE_DEF,
	parameter int FB_ROWS = msblit_pkg::FB_ROWS_DEF,
	localparam int FB_SIZE = FB_STRIDE * FB_ROWS,
	localparam int AW = (FB_SIZE > 1) ? $clog2(FB_SIZE) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	msblit_in_if.sink         req,
	output logic              push,
	output msblit_pkg::op_t   push_op,
	output logic [AW-1:0]     push_addr,
	input  logic              full
);
	// row base reaches start offset plus one stride per row, plus the columns
	localparam int RB_MAX = 94 + FB_STRIDE * 766;
	localparam int RB_RAW_W = $clog2(RB_MAX + 1);
	localparam int RB_W = (RB_RAW_W > AW) ? RB_RAW_W : AW;

	logic [RB_W-1:0] row_base_q;
	logic [2:0]      shift_q;
	logic [5:0]      col_q;
	logic [8:0]      row_q;
	logic [5:0]      width_q;
	logic [8:0]      height_q;
	logic [7:0]      prev_img_q;
	logic [7:0]      prev_mask_q;
	logic            active_q;

	logic            pend_q;
	logic [AW-1:0]   pend_addr_q;
	logic            pend_hit_q;
	logic [7:0]      pend_keep_q;
	logic [7:0]      pend_img_q;

	msblit_pkg::in_item_t it;
	logic            acc;
	logic            is_src;
	logic            last_col;
	logic [3:0]      spill_sh;
	logic [15:0]     head_keep;
	logic [15:0]     spill_keep;
	logic [15:0]     spill_img;
	logic [15:0]     tail_keep;
	logic [15:0]     tail_img;
	logic [7:0]      merge_keep;
	logic [7:0]      merge_img;
	logic [RB_W-1:0] cur_addr;
	logic [RB_W-1:0] nxt_addr;
	logic            cur_hit;
	logic            nxt_hit;
	logic            rd_hit;

	assign it = req.item;
	assign req.ready = !full && !pend_q;
	assign acc = req.valid && req.ready;
	assign is_src = acc && (it.cmd == msblit_pkg::CMD_SOURCE) && active_q;

	assign last_col = (({1'b0, col_q} + 7'd1) >= {1'b0, width_q});
	assign spill_sh = 4'd8 - {1'b0, shift_q};

	assign head_keep = 16'hFF00 >> shift_q;
	assign spill_keep = {8'h00, prev_mask_q} << spill_sh;
	assign spill_img = {8'h00, prev_img_q} << spill_sh;
	assign tail_keep = {8'h00, it.mask_byte} << spill_sh;
	assign tail_img = {8'h00, it.image_byte} << spill_sh;

	always_comb begin
		if (col_q == '0) begin
			merge_keep = head_keep[7:0] | (it.mask_byte >> shift_q);
			merge_img = it.image_byte >> shift_q;
		end else begin
			merge_keep = spill_keep[7:0] | (it.mask_byte >> shift_q);
			merge_img = spill_img[7:0] | (it.image_byte >> shift_q);
		end
	end

	assign cur_addr = row_base_q + RB_W'(col_q);
	assign nxt_addr = cur_addr + 1'b1;
	assign cur_hit = (32'(cur_addr) < 32'(FB_SIZE));
	assign nxt_hit = (32'(nxt_addr) < 32'(FB_SIZE));
	assign rd_hit = (32'(it.address) < 32'(FB_SIZE));

	always_comb begin
		push = 1'b0;
		push_op = '0;
		push_addr = '0;
		if (pend_q) begin
			push = !full;
			push_op.kind = msblit_pkg::OP_MERGE;
			push_op.hit = pend_hit_q;
			push_op.keep = pend_keep_q;
			push_op.data = pend_img_q;
			push_addr = pend_addr_q;
		end else if (acc) begin
			case (it.cmd)
				msblit_pkg::CMD_SOURCE: begin
					push = active_q;
					push_op.kind = msblit_pkg::OP_MERGE;
					push_op.hit = cur_hit;
					push_op.keep = merge_keep;
					push_op.data = merge_img;
					push_addr = AW'(cur_addr);
				end
				msblit_pkg::CMD_READ: begin
					push = 1'b1;
					push_op.kind = msblit_pkg::OP_READ;
					push_op.hit = rd_hit;
					push_addr = AW'(it.address);
				end
				msblit_pkg::CMD_WRITE: begin
					push = 1'b1;
					push_op.kind = msblit_pkg::OP_WRITE;
					push_op.hit = rd_hit;
					push_op.data = it.write_data;
					push_addr = AW'(it.address);
				end
				default: begin
					push = 1'b0;
				end
			endcase
		end
	end

	// trailing column byte of a row and previous source bytes
	always_ff @(posedge clk) begin
		if (is_src) begin
			prev_img_q <= it.image_byte;
			prev_mask_q <= it.mask_byte;
			pend_addr_q <= AW'(nxt_addr);
			pend_hit_q <= nxt_hit;
			pend_keep_q <= tail_keep[7:0] | (8'hFF >> shift_q);
			pend_img_q <= tail_img[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_base_q <= '0;
			shift_q <= '0;
			col_q <= '0;
			row_q <= '0;
			width_q <= '0;
			height_q <= '0;
			active_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			if (pend_q && !full) begin
				pend_q <= 1'b0;
			end
			if (acc && it.cmd == msblit_pkg::CMD_START) begin
				row_base_q <= RB_W'(it.pos_x[7:3]) + RB_W'(FB_STRIDE) * RB_W'(it.pos_y);
				shift_q <= it.pos_x[2:0];
				col_q <= '0;
				row_q <= '0;
				width_q <= it.width_bytes;
				height_q <= it.height_rows;
				active_q <= (it.width_bytes != '0) && (it.height_rows != '0);
			end else if (is_src) begin
				if (last_col) begin
					col_q <= '0;
					row_base_q <= row_base_q + RB_W'(FB_STRIDE);
					row_q <= row_q + 1'b1;
					if ((row_q + 1'b1) >= height_q) begin
						active_q <= 1'b0;
					end
					pend_q <= (shift_q != '0);
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end
endmodule

FILE: hw/rtl/msblit_back.sv
// back: framebuffer memory, read-modify-write sequencer and result register
module msblit_back #(
	parameter int FB_STRIDE = msblit_pkg::FB_STRIDE_DEF,
	parameter int FB_ROWS = msblit_pkg::FB_ROWS_DEF,
	localparam int FB_SIZE = FB_STRIDE * FB_ROWS,
	localparam int AW = (FB_SIZE > 1) ? $clog2(FB_SIZE) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            empty,
	input  msblit_pkg::op_t head_op,
	input  logic [AW-1:0]   head_addr,
	output logic            pop,
	msblit_out_if.source    rsp
);
	logic [7:0] mem [FB_SIZE];
	logic [7:0] rdata_q;

	msblit_pkg::bk_state_t state_q;
	msblit_pkg::bk_state_t state_nxt;

	logic       out_valid_q;
	logic [7:0] out_data_q;
	logic       out_free;
	logic       mem_we;
	logic [7:0] mem_wdata;
	logic       out_load;

	assign out_free = !out_valid_q || rsp.ready;
	assign rsp.valid = out_valid_q;
	assign rsp.item.read_data = out_data_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			msblit_pkg::BK_ISSUE: begin
				if (!empty) begin
					case (head_op.kind)
						msblit_pkg::OP_MERGE: state_nxt = msblit_pkg::BK_MERGE;
						msblit_pkg::OP_READ: begin
							if (out_free) begin
								state_nxt = msblit_pkg::BK_READ;
							end
						end
						default: state_nxt = msblit_pkg::BK_ISSUE;
					endcase
				end
			end
			msblit_pkg::BK_MERGE: state_nxt = msblit_pkg::BK_ISSUE;
			msblit_pkg::BK_READ: state_nxt = msblit_pkg::BK_ISSUE;
			default: state_nxt = msblit_pkg::BK_ISSUE;
		endcase
	end

	always_comb begin
		pop = 1'b0;
		mem_we = 1'b0;
		mem_wdata = head_op.data;
		out_load = 1'b0;
		case (state_q)
			msblit_pkg::BK_ISSUE: begin
				if (!empty && head_op.kind == msblit_pkg::OP_WRITE) begin
					pop = 1'b1;
					mem_we = head_op.hit;
				end
			end
			msblit_pkg::BK_MERGE: begin
				// the destination byte was read in the cycle before
				pop = 1'b1;
				mem_we = head_op.hit;
				mem_wdata = (rdata_q & head_op.keep) | head_op.data;
			end
			msblit_pkg::BK_READ: begin
				pop = 1'b1;
				out_load = 1'b1;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[head_addr] <= mem_wdata;
		end
		rdata_q <= mem[head_addr];
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= head_op.hit ? rdata_q : 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msblit_pkg::BK_ISSUE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

FILE: test/testbench.sv
// self-checking testbench for the masked sprite blitter: directed and random command items
module testbench;
	localparam int FB_BYTES = msblit_pkg::FB_STRIDE_DEF * msblit_pkg::FB_ROWS_DEF;
	localparam int LIMIT_CYCLES = 500000;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_ITEMS = 2000;

	// mirror of the framebuffer and blit state, plus the read data still owed
	class frame_scoreboard;
		logic [7:0] frame [FB_BYTES];
		int line_base;
		int shift;
		int col;
		int rows_done;
		int spr_w;
		int spr_h;
		logic [7:0] prev_pix;
		logic [7:0] prev_keep;
		bit drawing;
		logic [7:0] read_queue [$];
		int mismatches;
		int effective;
		int reads_checked;
		int blits;
		int drawn;

		task report(string what);
			$display("mismatch: %s", what);
			mismatches++;
		endtask

		function void merge(int addr, logic [7:0] keep, logic [7:0] pix);
			if (addr < FB_BYTES) begin
				frame[addr] = (frame[addr] & keep) | pix;
			end
		endfunction

		function void draw_byte(logic [7:0] im, logic [7:0] mk);
			logic [15:0] keep;
			logic [15:0] pix;
			if (col == 0) begin
				keep = (16'hFF00 >> shift) | ({8'h00, mk} >> shift);
				pix = {8'h00, im} >> shift;
			end else begin
				keep = ({8'h00, prev_keep} << (8 - shift)) | ({8'h00, mk} >> shift);
				pix = ({8'h00, prev_pix} << (8 - shift)) | ({8'h00, im} >> shift);
			end
			merge(line_base + col, keep[7:0], pix[7:0]);
			if (col + 1 >= spr_w) begin
				// last byte of a shifted row spills into the trailing column
				if (shift != 0) begin
					keep = ({8'h00, mk} << (8 - shift)) | (16'h00FF >> shift);
					pix = {8'h00, im} << (8 - shift);
					merge(line_base + col + 1, keep[7:0], pix[7:0]);
				end
				col = 0;
				line_base += msblit_pkg::FB_STRIDE_DEF;
				rows_done++;
				if (rows_done >= spr_h) begin
					drawing = 1'b0;
				end
			end else begin
				col++;
			end
			prev_pix = im;
			prev_keep = mk;
			drawn++;
		endfunction

		function void note(msblit_pkg::in_item_t it);
			case (it.cmd)
				msblit_pkg::CMD_START: begin
					line_base = int'(it.pos_x >> 3)
						+ msblit_pkg::FB_STRIDE_DEF * int'(it.pos_y);
					shift = int'(it.pos_x[2:0]);
					col = 0;
					rows_done = 0;
					spr_w = int'(it.width_bytes);
					spr_h = int'(it.height_rows);
					prev_pix = '0;
					prev_keep = '0;
					drawing = (spr_w != 0) && (spr_h != 0);
					blits++;
					effective++;
				end
				msblit_pkg::CMD_SOURCE: begin
					if (drawing) begin
						draw_byte(it.image_byte, it.mask_byte);
						effective++;
					end
				end
				msblit_pkg::CMD_READ: begin
					read_queue.push_back(it.address < FB_BYTES ? frame[it.address] : 8'h00);
					effective++;
				end
				msblit_pkg::CMD_WRITE: begin
					if (it.address < FB_BYTES) begin
						frame[it.address] = it.write_data;
					end
					effective++;
				end
				default: begin
				end
			endcase
		endfunction

		task check_read(msblit_pkg::out_item_t got);
			logic [7:0] want;
			if (read_queue.size() == 0) begin
				report($sformatf("read data %02h with no read outstanding", got.read_data));
			end else begin
				want = read_queue.pop_front();
				reads_checked++;
				if (got.read_data !== want) begin
					report($sformatf("read data %02h, predicted %02h", got.read_data, want));
				end
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	msblit_in_if req_ch ();
	msblit_out_if rsp_ch ();

	masked_sprite_blit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	frame_scoreboard sb = new();
	bit primed [FB_BYTES];
	int primed_list [$];
	bit calm_source = 1'b0;
	bit calm_sink = 1'b0;
	bit hold_armed = 1'b1;
	int cycle_count;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d reads outstanding", cycle_count,
			sb.read_queue.size());
		$display("*** FAILED ***");
		$finish;
	end

	task automatic send(msblit_pkg::in_item_t it);
		int gap;
		gap = calm_source ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.item <= it;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		sb.note(it);
	endtask

	// unused fields carry random junk
	function automatic msblit_pkg::in_item_t noise_item(msblit_pkg::cmd_t cmd);
		logic [95:0] junk;
		msblit_pkg::in_item_t it;
		junk = {$urandom, $urandom, $urandom};
		it = junk[$bits(msblit_pkg::in_item_t)-1:0];
		it.cmd = cmd;
		return it;
	endfunction

	task automatic write_byte(int a, logic [7:0] d);
		msblit_pkg::in_item_t it;
		it = noise_item(msblit_pkg::CMD_WRITE);
		it.address = 13'(a);
		it.write_data = d;
		if (!primed[a]) begin
			primed[a] = 1'b1;
			primed_list.push_back(a);
		end
		send(it);
	endtask

	task automatic read_byte(int a);
		msblit_pkg::in_item_t it;
		it = noise_item(msblit_pkg::CMD_READ);
		it.address = 13'(a);
		send(it);
	endtask

	task automatic source(logic [7:0] im, logic [7:0] mk);
		msblit_pkg::in_item_t it;
		it = noise_item(msblit_pkg::CMD_SOURCE);
		it.image_byte = im;
		it.mask_byte = mk;
		send(it);
	endtask

	task automatic start_blit(int px, int py, int wb, int hr);
		msblit_pkg::in_item_t it;
		int base;
		int span;
		int a;
		base = px / 8 + msblit_pkg::FB_STRIDE_DEF * py;
		span = wb + ((px % 8) != 0);
		// every byte the blit merges into must hold known data first
		if (wb > 0) begin
			for (int r = 0; r < hr && base + r * msblit_pkg::FB_STRIDE_DEF < FB_BYTES; r++) begin
				for (int c = 0; c < span; c++) begin
					a = base + r * msblit_pkg::FB_STRIDE_DEF + c;
					if (a < FB_BYTES && !primed[a]) begin
						write_byte(a, 8'($urandom));
					end
				end
			end
		end
		it = noise_item(msblit_pkg::CMD_START);
		it.pos_x = 8'(px);
		it.pos_y = 8'(py);
		it.width_bytes = 6'(wb);
		it.height_rows = 9'(hr);
		send(it);
	endtask

	task automatic read_back(int px, int py, int wb, int hr, int count);
		int a;
		repeat (count) begin
			a = px / 8 + msblit_pkg::FB_STRIDE_DEF * (py + $urandom_range(0, hr - 1))
				+ $urandom_range(0, wb);
			if (a < FB_BYTES && primed[a]) begin
				read_byte(a);
			end
		end
	endtask

	task automatic random_access();
		if (primed_list.size() > 0 && $urandom_range(0, 2) != 0) begin
			read_byte(primed_list[$urandom_range(0, primed_list.size() - 1)]);
		end else begin
			write_byte($urandom_range(0, FB_BYTES - 1), 8'($urandom));
		end
	endtask

	task automatic blit_sequence();
		int px;
		int py;
		int wb;
		int hr;
		int total;
		int cut;
		logic [7:0] mk;
		px = ($urandom_range(0, 3) == 0) ? 8 * $urandom_range(0, 31) : $urandom_range(0, 255);
		py = $urandom_range(0, 255);
		case ($urandom_range(0, 29))
			0, 1: begin
				wb = $urandom_range(5, 63);
				hr = $urandom_range(1, 3);
			end
			2: begin
				wb = $urandom_range(1, 2);
				hr = $urandom_range(9, 40);
			end
			default: begin
				wb = $urandom_range(1, 4);
				hr = $urandom_range(1, 6);
			end
		endcase
		total = wb * hr;
		// now and then the sprite is cut short and the next start abandons it
		cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, total - 1) : total;
		start_blit(px, py, wb, hr);
		for (int i = 0; i < cut; i++) begin
			if ($urandom_range(0, 11) == 0) begin
				random_access();
			end
			case ($urandom_range(0, 7))
				0: mk = 8'h00;
				1: mk = 8'hFF;
				default: mk = 8'($urandom);
			endcase
			source(8'($urandom), mk);
		end
		read_back(px, py, wb, hr, (total < 8) ? total : 8);
		if ($urandom_range(0, 4) == 0) begin
			source(8'($urandom), 8'($urandom));
		end
	endtask

	task automatic noise_sequence();
		if ($urandom_range(0, 3) == 0) begin
			// empty sprite followed by a source item that has nothing to draw into
			if ($urandom_range(0, 1) == 0) begin
				start_blit($urandom_range(0, 255), $urandom_range(0, 255), 0,
					$urandom_range(0, 511));
			end else begin
				start_blit($urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 63), 0);
			end
			source(8'($urandom), 8'($urandom));
		end else begin
			repeat ($urandom_range(1, 6)) random_access();
		end
	endtask

	initial begin : result_sink
		int pause;
		int taken;
		taken = 0;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			pause = calm_sink ? 0 : $urandom_range(0, 3);
			// one long hold-off so the queue fills and the input stalls
			if (hold_armed && sb.reads_checked >= 3) begin
				pause = HOLD_CYCLES;
				hold_armed = 1'b0;
			end
			if (pause > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (pause) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
			sb.check_read(rsp_ch.item);
			taken++;
			if (taken % 40 == 0) begin
				calm_sink = ($urandom_range(0, 3) == 0);
			end
		end
	end

	initial begin : stimulus
		int target;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.item <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_byte(0, 8'h00);
		write_byte(FB_BYTES - 1, 8'hFF);
		read_byte(FB_BYTES - 1);
		read_byte(0);
		source(8'hFF, 8'h00);
		start_blit(100, 50, 0, 5);
		source(8'hFF, 8'h00);
		start_blit(100, 50, 3, 0);
		// largest sprite at the far corner: most writes land past the end, then abandoned
		start_blit(255, 255, 63, 511);
		source(8'hFF, 8'h00);
		source(8'h81, 8'h7E);
		source(8'h00, 8'hFF);
		read_byte(FB_BYTES - 1);
		start_blit(0, 0, 1, 1);
		source(8'hC3, 8'h3C);
		read_byte(0);
		// shifted sprite running off the right edge into the next row
		start_blit(253, 10, 2, 2);
		source(8'hFF, 8'h00);
		read_byte(FB_BYTES - 1);
		source(8'hA5, 8'h0F);
		write_byte(FB_BYTES - 1, 8'h5A);
		source(8'h00, 8'hFF);
		source(8'h3C, 8'hC3);
		read_back(253, 10, 2, 2, 6);

		target = sb.effective + RANDOM_ITEMS;
		while (sb.effective < target) begin
			calm_source = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 3) != 0) begin
				blit_sequence();
			end else begin
				noise_sequence();
			end
		end
		req_ch.valid <= 1'b0;

		while (sb.read_queue.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("run covered %0d items: %0d blit starts, %0d sprite bytes drawn, %0d reads",
			sb.effective, sb.blits, sb.drawn, sb.reads_checked);
		$display("%0d mismatches in %0d cycles", sb.mismatches, cycle_count);
		if (sb.mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule

FILE: files.f
hw/rtl/msblit_pkg.sv
hw/rtl/msblit_if.sv
hw/rtl/msblit_fifo.sv
hw/rtl/msblit_front.sv
hw/rtl/msblit_back.sv
hw/rtl/masked_sprite_blit.sv
test/testbench.sv
